>>> design/rrps_pkg.sv
package rrps_pkg;

    // default table size and quantum after reset
    localparam int MAX_PROCS_DEF = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd4;

    // stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 232;

    // datapath operation codes sent by the controller
    localparam logic [3:0] OP_WAIT     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_INIT_EV  = 4'd2;
    localparam logic [3:0] OP_ENQ_EV   = 4'd3;
    localparam logic [3:0] OP_CHECK    = 4'd4;
    localparam logic [3:0] OP_NEXT_EV  = 4'd5;
    localparam logic [3:0] OP_NEXT_END = 4'd6;
    localparam logic [3:0] OP_POP_EV   = 4'd7;
    localparam logic [3:0] OP_RUN_EV   = 4'd8;
    localparam logic [3:0] OP_RETIRE   = 4'd9;
    localparam logic [3:0] OP_OUT_EV   = 4'd10;
    localparam logic [3:0] OP_OUT_WAIT = 4'd11;
    localparam logic [3:0] OP_CLEAR    = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       win_open;
    } rrps_cmd_t;

    typedef struct packed {
        logic in_last_fire;
        logic out_fire;
        logic scan_last;
        logic all_done;
        logic ring_empty;
        logic next_none;
    } rrps_stat_t;

    typedef struct packed {
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [15:0] pid;
    } rrps_rec_t;

endpackage

>>> design/rrps_ram.sv
module rrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/rrps_ctrl.sv
module rrps_ctrl import rrps_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  rrps_stat_t stat,
    output rrps_cmd_t  cmd
);

    localparam logic [4:0] ST_LOAD     = 5'd0;
    localparam logic [4:0] ST_INIT_RD  = 5'd1;
    localparam logic [4:0] ST_INIT_EV  = 5'd2;
    localparam logic [4:0] ST_ENQ_RD   = 5'd3;
    localparam logic [4:0] ST_ENQ_EV   = 5'd4;
    localparam logic [4:0] ST_CHECK    = 5'd5;
    localparam logic [4:0] ST_NEXT_RD  = 5'd6;
    localparam logic [4:0] ST_NEXT_EV  = 5'd7;
    localparam logic [4:0] ST_NEXT_END = 5'd8;
    localparam logic [4:0] ST_POP_RD   = 5'd9;
    localparam logic [4:0] ST_POP_EV   = 5'd10;
    localparam logic [4:0] ST_RUN_EV   = 5'd11;
    localparam logic [4:0] ST_WIN_RD   = 5'd12;
    localparam logic [4:0] ST_WIN_EV   = 5'd13;
    localparam logic [4:0] ST_RETIRE   = 5'd14;
    localparam logic [4:0] ST_OUT_RD   = 5'd15;
    localparam logic [4:0] ST_OUT_EV   = 5'd16;
    localparam logic [4:0] ST_OUT_WAIT = 5'd17;
    localparam logic [4:0] ST_CLEAR    = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_WAIT;
        cmd.win_open = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.op = OP_LOAD;
                if (stat.in_last_fire)
                begin
                    state_next = ST_INIT_RD;
                end
            end
            ST_INIT_RD:  state_next = ST_INIT_EV;
            ST_INIT_EV:
            begin
                cmd.op     = OP_INIT_EV;
                state_next = stat.scan_last ? ST_ENQ_RD : ST_INIT_RD;
            end
            ST_ENQ_RD:   state_next = ST_ENQ_EV;
            ST_ENQ_EV:
            begin
                cmd.op     = OP_ENQ_EV;
                state_next = stat.scan_last ? ST_CHECK : ST_ENQ_RD;
            end
            ST_CHECK:
            begin
                cmd.op = OP_CHECK;
                if (stat.all_done)
                begin
                    state_next = ST_OUT_RD;
                end
                else if (stat.ring_empty)
                begin
                    state_next = ST_NEXT_RD;
                end
                else
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_NEXT_RD:  state_next = ST_NEXT_EV;
            ST_NEXT_EV:
            begin
                cmd.op     = OP_NEXT_EV;
                state_next = stat.scan_last ? ST_NEXT_END : ST_NEXT_RD;
            end
            ST_NEXT_END:
            begin
                cmd.op     = OP_NEXT_END;
                state_next = stat.next_none ? ST_OUT_RD : ST_ENQ_RD;
            end
            ST_POP_RD:   state_next = ST_POP_EV;
            ST_POP_EV:
            begin
                cmd.op     = OP_POP_EV;
                state_next = ST_RUN_EV;
            end
            ST_RUN_EV:
            begin
                cmd.op     = OP_RUN_EV;
                state_next = ST_WIN_RD;
            end
            ST_WIN_RD:   state_next = ST_WIN_EV;
            ST_WIN_EV:
            begin
                cmd.op       = OP_ENQ_EV;
                cmd.win_open = 1'b1;
                state_next   = stat.scan_last ? ST_RETIRE : ST_WIN_RD;
            end
            ST_RETIRE:
            begin
                cmd.op     = OP_RETIRE;
                state_next = ST_CHECK;
            end
            ST_OUT_RD:   state_next = ST_OUT_EV;
            ST_OUT_EV:
            begin
                cmd.op     = OP_OUT_EV;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                cmd.op = OP_OUT_WAIT;
                if (stat.out_fire)
                begin
                    state_next = stat.scan_last ? ST_CLEAR : ST_OUT_RD;
                end
            end
            ST_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = ST_LOAD;
            end
            default:     state_next = ST_LOAD;
        endcase
    end

endmodule

>>> design/rrps_dpath.sv
module rrps_dpath import rrps_pkg::*; #(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  rrps_cmd_t             cmd,
    output rrps_stat_t            stat
);

    localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int TW  = 16 + $clog2(MAX_PROCS + 1);
    localparam int RUW = 16 + 2 * TW;

    logic [15:0]    quantum_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  ring_cnt_reg;
    logic [CW-1:0]  completed_reg;
    logic [IW-1:0]  j_reg;
    logic [IW-1:0]  idx_reg;
    logic [IW-1:0]  head_reg;
    logic [IW-1:0]  tail_reg;
    logic [IW-1:0]  ld_idx_reg;
    logic           ld_valid_reg;
    logic [TW-1:0]  cur_reg;
    logic [TW-1:0]  old_reg;
    logic [TW-1:0]  next_reg;
    logic [MAX_PROCS-1:0] started_reg;
    logic [MAX_PROCS-1:0] done_reg;
    logic [MAX_PROCS-1:0] queued_reg;
    logic [19:0]    switch_reg;
    logic           dropped_reg;
    logic [15:0]    rem_reg;
    logic [TW-1:0]  first_reg;
    logic [27:0]    sr_reg;
    logic [27:0]    sw_reg;
    logic [27:0]    st_reg;
    logic           out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic           out_last_reg;

    logic           in_fire;
    logic           out_fire;
    rrps_rec_t      in_rec;
    rrps_rec_t      rec_rd;
    logic           rec_we;
    logic [RUW-1:0] run_rd;
    logic           run_we;
    logic [IW-1:0]  run_waddr;
    logic [RUW-1:0] run_wdata;
    logic [IW-1:0]  run_raddr;
    logic [IW-1:0]  ring_rd;
    logic           push_en;
    logic [IW-1:0]  push_idx;
    logic           enq_cand;
    logic           j_adv;
    logic [15:0]    q_eff;
    logic [15:0]    run_rem;
    logic [TW-1:0]  run_first;
    logic [TW-1:0]  run_fin;
    logic [15:0]    slice;
    logic [TW-1:0]  arr_w;
    logic [31:0]    resp_w;
    logic [31:0]    tat_w;
    logic [31:0]    wait_w;

    assign in_rec        = rrps_rec_t'(s_axis_tdata);
    assign s_axis_tready = (cmd.op == OP_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_fire      = out_valid_reg && m_axis_tready;

    assign arr_w     = TW'(rec_rd.arrival);
    assign run_rem   = run_rd[RUW-1:2*TW];
    assign run_first = run_rd[2*TW-1:TW];
    assign run_fin   = run_rd[TW-1:0];
    assign q_eff     = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign slice     = (run_rem < q_eff) ? run_rem : q_eff;

    // status back to the controller
    assign stat.in_last_fire = in_fire && s_axis_tlast;
    assign stat.out_fire     = out_fire;
    assign stat.scan_last    = ((CW'(j_reg) + CW'(1)) == count_reg);
    assign stat.all_done     = (completed_reg == count_reg);
    assign stat.ring_empty   = (ring_cnt_reg == '0);
    assign stat.next_none    = (next_reg == '1);

    // record table, run table and ready ring
    assign rec_we = in_fire && (count_reg < CW'(MAX_PROCS));

    rrps_ram #(.WIDTH(48), .DEPTH(MAX_PROCS)) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_rec),
        .rd_addr (j_reg),
        .rd_data (rec_rd)
    );

    assign run_raddr = (cmd.op == OP_POP_EV) ? ring_rd : j_reg;

    always_comb
    begin
        run_we    = 1'b0;
        run_waddr = j_reg;
        run_wdata = {rec_rd.burst, {TW{1'b0}}, {TW{1'b0}}};
        if (cmd.op == OP_INIT_EV)
        begin
            run_we = 1'b1;
        end
        else if (cmd.op == OP_RETIRE)
        begin
            run_we    = 1'b1;
            run_waddr = idx_reg;
            run_wdata = {rem_reg, first_reg, cur_reg};
        end
    end

    rrps_ram #(.WIDTH(RUW), .DEPTH(MAX_PROCS)) u_run_ram (
        .clk     (clk),
        .wr_en   (run_we),
        .wr_addr (run_waddr),
        .wr_data (run_wdata),
        .rd_addr (run_raddr),
        .rd_data (run_rd)
    );

    // arrival window test for the queue scan
    assign enq_cand = !done_reg[j_reg] && !queued_reg[j_reg] && (arr_w <= cur_reg)
                      && (!cmd.win_open || (arr_w > old_reg));

    always_comb
    begin
        push_en  = 1'b0;
        push_idx = j_reg;
        if (cmd.op == OP_ENQ_EV)
        begin
            push_en = enq_cand;
        end
        else if (cmd.op == OP_RETIRE)
        begin
            push_en  = (rem_reg != 16'd0);
            push_idx = idx_reg;
        end
        if (ring_cnt_reg >= CW'(MAX_PROCS) || queued_reg[push_idx])
        begin
            push_en = 1'b0;
        end
    end

    rrps_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_ring_ram (
        .clk     (clk),
        .wr_en   (push_en),
        .wr_addr (tail_reg),
        .wr_data (push_idx),
        .rd_addr (head_reg),
        .rd_data (ring_rd)
    );

    assign j_adv = (cmd.op == OP_INIT_EV) || (cmd.op == OP_ENQ_EV) || (cmd.op == OP_NEXT_EV)
                   || ((cmd.op == OP_OUT_WAIT) && out_fire);

    // per-result times
    assign resp_w = 32'(run_first) - 32'(arr_w);
    assign tat_w  = 32'(run_fin) - 32'(arr_w);
    assign wait_w = tat_w - 32'(rec_rd.burst);

    // control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= QUANTUM_RESET;
            count_reg     <= '0;
            ring_cnt_reg  <= '0;
            completed_reg <= '0;
            j_reg         <= '0;
            idx_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            ld_idx_reg    <= '0;
            ld_valid_reg  <= 1'b0;
            cur_reg       <= '0;
            old_reg       <= '0;
            next_reg      <= '0;
            started_reg   <= '0;
            done_reg      <= '0;
            queued_reg    <= '0;
            switch_reg    <= '0;
            dropped_reg   <= 1'b0;
            rem_reg       <= '0;
            first_reg     <= '0;
            sr_reg        <= '0;
            sw_reg        <= '0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                quantum_reg <= cfg_wr_data;
            end

            // scan index walks the loaded records
            if (j_adv)
            begin
                j_reg <= stat.scan_last ? '0 : j_reg + 1'b1;
            end

            // ring insert
            if (push_en)
            begin
                queued_reg[push_idx] <= 1'b1;
                tail_reg     <= (tail_reg == IW'(MAX_PROCS - 1)) ? '0 : tail_reg + 1'b1;
                ring_cnt_reg <= ring_cnt_reg + 1'b1;
            end

            case (cmd.op)
                OP_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (rec_we)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            cur_reg <= '1;
                        end
                    end
                end
                OP_INIT_EV:
                begin
                    if (arr_w < cur_reg)
                    begin
                        cur_reg <= arr_w;
                    end
                end
                OP_CHECK:
                begin
                    next_reg <= '1;
                end
                OP_NEXT_EV:
                begin
                    if (!done_reg[j_reg] && (arr_w > cur_reg) && (arr_w < next_reg))
                    begin
                        next_reg <= arr_w;
                    end
                end
                OP_NEXT_END:
                begin
                    if (next_reg != '1)
                    begin
                        cur_reg <= next_reg;
                    end
                end
                OP_POP_EV:
                begin
                    idx_reg             <= ring_rd;
                    queued_reg[ring_rd] <= 1'b0;
                    head_reg     <= (head_reg == IW'(MAX_PROCS - 1)) ? '0 : head_reg + 1'b1;
                    ring_cnt_reg <= ring_cnt_reg - 1'b1;
                    if (!ld_valid_reg || (ld_idx_reg != ring_rd))
                    begin
                        switch_reg   <= switch_reg + 1'b1;
                        ld_idx_reg   <= ring_rd;
                        ld_valid_reg <= 1'b1;
                    end
                end
                OP_RUN_EV:
                begin
                    if (!started_reg[idx_reg])
                    begin
                        started_reg[idx_reg] <= 1'b1;
                        first_reg            <= cur_reg;
                    end
                    else
                    begin
                        first_reg <= run_first;
                    end
                    old_reg <= cur_reg;
                    cur_reg <= cur_reg + TW'(slice);
                    rem_reg <= run_rem - slice;
                end
                OP_RETIRE:
                begin
                    if (rem_reg == 16'd0)
                    begin
                        done_reg[idx_reg] <= 1'b1;
                        completed_reg     <= completed_reg + 1'b1;
                    end
                end
                OP_OUT_EV:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= stat.scan_last;
                    out_data_reg  <= {6'd0, dropped_reg, switch_reg,
                                      st_reg + tat_w[27:0], sw_reg + wait_w[27:0],
                                      sr_reg + resp_w[27:0],
                                      tat_w[20:0], wait_w[20:0], resp_w[20:0],
                                      run_fin[20:0] & {21{1'b1}} , run_first[20:0],
                                      rec_rd.pid};
                    sr_reg <= sr_reg + resp_w[27:0];
                    sw_reg <= sw_reg + wait_w[27:0];
                    st_reg <= st_reg + tat_w[27:0];
                end
                OP_OUT_WAIT:
                begin
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                OP_CLEAR:
                begin
                    count_reg     <= '0;
                    ring_cnt_reg  <= '0;
                    completed_reg <= '0;
                    j_reg         <= '0;
                    head_reg      <= '0;
                    tail_reg      <= '0;
                    ld_valid_reg  <= 1'b0;
                    cur_reg       <= '0;
                    started_reg   <= '0;
                    done_reg      <= '0;
                    queued_reg    <= '0;
                    switch_reg    <= '0;
                    dropped_reg   <= 1'b0;
                    sr_reg        <= '0;
                    sw_reg        <= '0;
                    st_reg        <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ring occupancy matches the queued marks
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == int'(ring_cnt_reg))
        else $error("ring count out of step with queued marks");

    // never more finished processes than loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        completed_reg <= count_reg)
        else $error("completed count beyond record count");

    // loading and result delivery never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && out_valid_reg))
        else $error("input open while a result is pending");

endmodule

>>> design/round_robin_process_scheduler_core.sv
// Round-robin scheduler: process records (pid, arrival, burst) stream in at one per
// cycle into a table of MAX_PROCS entries; records beyond that are dropped and flagged.
// The record with tlast starts the schedule, and input stays closed until every result
// of the run has been transferred. The schedule is run by a controller over one shared
// table port, so its length grows with the work: initial scans for the earliest arrival
// and the first enqueue pass, then per dispatch a scan of the arrival window, and per
// idle gap a scan for the next arrival followed by another enqueue pass.
// Results then come out one per process in load order, each held until the sink takes
// it, and a one-cycle clear follows the last one. The quantum register is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. A quantum of zero acts as one.
module round_robin_process_scheduler_core import rrps_pkg::*; #(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // proc_id, arrival_time, burst_time
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_proc_id, first_run_time, finish_time, response_time, waiting_time,
    // turnaround_time, sum_response, sum_waiting, sum_turnaround,
    // context_switches, records_dropped, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    rrps_cmd_t  cmd;
    rrps_stat_t stat;

    rrps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    rrps_dpath #(.MAX_PROCS(MAX_PROCS)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> dv/rrps_checker.sv
`timescale 1ns / 100ps

module rrps_checker import rrps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    errors,
    output int                    results_waiting,
    output int                    results_seen
);

    localparam int NPROC = MAX_PROCS_DEF;
    localparam int NFIELD = 12;

    // result field layout from the lowest bit up, tlast handled apart
    localparam int FLD_LO [NFIELD-1] = '{0, 16, 37, 58, 79, 100, 121, 149, 177, 205, 225};
    localparam int FLD_W  [NFIELD-1] = '{16, 21, 21, 21, 21, 21, 28, 28, 28, 20, 1};
    localparam string FLD_NAME [NFIELD-1] = '{"proc_id", "first_run", "finish", "response",
        "waiting", "turnaround", "sum_response", "sum_waiting", "sum_turnaround",
        "context_switches", "records_dropped"};

    typedef struct {
        logic [OUT_DATA_W-1:0] data;
        logic                  last;
    } sched_result_t;

    sched_result_t result_q [$];

    // batch being loaded and the quantum shadow
    logic [15:0] quantum;
    logic [15:0] rec_pid   [NPROC];
    logic [15:0] rec_arr   [NPROC];
    logic [15:0] rec_burst [NPROC];
    int          rec_count;
    bit          rec_dropped;

    // schedule working state
    bit          done_f   [NPROC];
    bit          queued_f [NPROC];
    int          ready_q  [$];

    // queue every unfinished process arriving in the window, in load order
    function automatic void admit_window(int unsigned lo, int unsigned hi, bit open_low);
        for (int j = 0; j < rec_count; j++)
        begin
            if (!done_f[j] && !queued_f[j] && rec_arr[j] <= hi && (!open_low || rec_arr[j] > lo))
            begin
                ready_q.push_back(j);
                queued_f[j] = 1'b1;
            end
        end
    endfunction

    function automatic void schedule_batch();
        int unsigned rem [NPROC];
        int unsigned first_t [NPROC];
        int unsigned fin_t [NPROC];
        bit          started [NPROC];
        int unsigned now, q, nxt, slice, old_t, switches;
        int unsigned resp, tat, wt, sr, sw, st;
        int          prev_idx, completed, idx;
        sched_result_t r;
        q = (quantum == 16'd0) ? 1 : quantum;
        now = 32'hFFFF_FFFF;
        ready_q.delete();
        for (int i = 0; i < NPROC; i++)
        begin
            done_f[i] = 0;
            queued_f[i] = 0;
            started[i] = 0;
        end
        for (int i = 0; i < rec_count; i++)
        begin
            rem[i] = rec_burst[i];
            if (rec_arr[i] < now)
                now = rec_arr[i];
        end
        if (rec_count == 0)
            now = 0;
        admit_window(0, now, 1'b0);
        prev_idx = -1;
        switches = 0;
        completed = 0;
        while (completed < rec_count)
        begin
            if (ready_q.size() == 0)
            begin
                // idle gap: jump to the next arrival
                nxt = 32'hFFFF_FFFF;
                for (int i = 0; i < rec_count; i++)
                    if (!done_f[i] && rec_arr[i] > now && rec_arr[i] < nxt)
                        nxt = rec_arr[i];
                if (nxt == 32'hFFFF_FFFF)
                    break;
                now = nxt;
                admit_window(0, now, 1'b0);
                continue;
            end
            idx = ready_q.pop_front();
            queued_f[idx] = 0;
            if (idx != prev_idx)
            begin
                switches++;
                prev_idx = idx;
            end
            if (!started[idx])
            begin
                started[idx] = 1;
                first_t[idx] = now;
            end
            slice = (rem[idx] < q) ? rem[idx] : q;
            old_t = now;
            now += slice;
            rem[idx] -= slice;
            // arrivals inside the slice go ahead of the preempted process
            admit_window(old_t, now, 1'b1);
            if (rem[idx] == 0)
            begin
                done_f[idx] = 1;
                fin_t[idx] = now;
                completed++;
            end
            else
            begin
                ready_q.push_back(idx);
                queued_f[idx] = 1;
            end
        end
        sr = 0;
        sw = 0;
        st = 0;
        for (int i = 0; i < rec_count; i++)
        begin
            resp = first_t[i] - rec_arr[i];
            tat = fin_t[i] - rec_arr[i];
            wt = tat - rec_burst[i];
            sr += resp;
            sw += wt;
            st += tat;
            r.data = '0;
            r.data[15:0]    = rec_pid[i];
            r.data[36:16]   = first_t[i][20:0];
            r.data[57:37]   = fin_t[i][20:0];
            r.data[78:58]   = resp[20:0];
            r.data[99:79]   = wt[20:0];
            r.data[120:100] = tat[20:0];
            r.data[148:121] = sr[27:0];
            r.data[176:149] = sw[27:0];
            r.data[204:177] = st[27:0];
            r.data[224:205] = switches[19:0];
            r.data[225]     = rec_dropped;
            r.last = (i == rec_count - 1);
            result_q.push_back(r);
        end
        rec_count = 0;
        rec_dropped = 0;
    endfunction

    assign results_waiting = result_q.size();

    // watch config writes, record transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum = QUANTUM_RESET;
            rec_count = 0;
            rec_dropped = 0;
            errors = 0;
            results_seen = 0;
            result_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                quantum = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transfer, data %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    sched_result_t r;
                    r = result_q.pop_front();
                    for (int f = 0; f < NFIELD - 1; f++)
                    begin
                        logic [27:0] ev, av;
                        ev = 28'((r.data >> FLD_LO[f]) & ((232'd1 << FLD_W[f]) - 1));
                        av = 28'((m_axis_tdata >> FLD_LO[f]) & ((232'd1 << FLD_W[f]) - 1));
                        if (ev !== av)
                        begin
                            errors++;
                            $display("%0t: %s mismatch, expected %0d actual %0d",
                                     $time, FLD_NAME[f], ev, av);
                        end
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:226] !== '0)
                    begin
                        errors++;
                        $display("%0t: fill bits mismatch, expected 0 actual %h",
                                 $time, m_axis_tdata[OUT_DATA_W-1:226]);
                    end
                    if (m_axis_tlast !== r.last)
                    begin
                        errors++;
                        $display("%0t: last_result mismatch, expected %b actual %b",
                                 $time, r.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (rec_count < NPROC)
                begin
                    rec_pid[rec_count]   = s_axis_tdata[15:0];
                    rec_arr[rec_count]   = s_axis_tdata[31:16];
                    rec_burst[rec_count] = s_axis_tdata[47:32];
                    rec_count++;
                end
                else
                    rec_dropped = 1;
                if (s_axis_tlast)
                    schedule_batch();
            end
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rrps_pkg::*;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_wr_en = 0;
    logic [15:0]           cfg_wr_data = '0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int errors;
    int results_waiting;
    int results_seen;
    int records_sent;
    int batches_run;
    bit steady;
    logic [15:0] cur_quantum;

    always #2 clk = ~clk;

    round_robin_process_scheduler_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    rrps_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .errors(errors), .results_waiting(results_waiting), .results_seen(results_seen)
    );

    // result sink backpressure
    always @(negedge clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 13);

    // one record transfer, with random idle cycles ahead of it
    task automatic send_record(logic [15:0] pid, logic [15:0] arr, logic [15:0] burst,
                               logic last);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {burst, arr, pid};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        records_sent++;
    endtask

    // quantum write once the block has drained
    task automatic set_quantum(logic [15:0] q);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= q;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_quantum = q;
    endtask

    // random batch; bursts kept within a few slices so the walk stays short
    task automatic random_batch();
        int n, cap, q;
        bit spread;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
        q = (cur_quantum == 0) ? 1 : cur_quantum;
        cap = (q * 6 > 65535) ? 65535 : q * 6;
        spread = $urandom_range(0, 2) == 0;
        for (int i = 0; i < n; i++)
            send_record(16'($urandom_range(0, 65535)),
                        16'(spread ? $urandom_range(0, 65535) : $urandom_range(0, 40)),
                        16'($urandom_range(1, cap)), i == n - 1);
        batches_run++;
    endtask

    initial
    begin
        logic [15:0] q_list [8];
        records_sent = 0;
        batches_run = 0;
        steady = 0;
        cur_quantum = QUANTUM_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero burst, idle gap, quantum zero and maximum
        send_record(16'h0000, 16'd0, 16'd5, 1'b0);
        send_record(16'hFFFF, 16'd0, 16'd1, 1'b0);
        send_record(16'h1234, 16'd3, 16'd0, 1'b1);
        send_record(16'h00AA, 16'd7, 16'd9, 1'b1);
        set_quantum(16'hFFFF);
        send_record(16'h0005, 16'hFFFF, 16'hFFFF, 1'b0);
        send_record(16'h5555, 16'hFFFE, 16'h8000, 1'b1);
        send_record(16'hAAAA, 16'd10, 16'd2, 1'b0);
        send_record(16'h0F0F, 16'd1000, 16'd3, 1'b1);
        set_quantum(16'h0000);
        send_record(16'h0001, 16'd5, 16'd3, 1'b0);
        send_record(16'h0002, 16'd5, 16'd2, 1'b0);
        send_record(16'h0003, 16'd6, 16'd0, 1'b1);
        set_quantum(16'd1);
        send_record(16'h0004, 16'd2, 16'd4, 1'b0);
        send_record(16'h0006, 16'd0, 16'd3, 1'b0);
        send_record(16'h0007, 16'd1, 16'd2, 1'b1);

        // random batches over several quanta
        q_list = '{16'd1, 16'd2, 16'hFFFF, 16'd3, 16'd0, 16'd7, 16'h0000, 16'd4};
        for (int p = 0; p < 8 || records_sent < 200; p++)
        begin
            if (p % 8 == 6)
                set_quantum(16'($urandom_range(1, 65535)));
            else
                set_quantum(q_list[p % 8]);
            steady = (p % 8 == 3);
            repeat (2) random_batch();
        end
        steady = 0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("covered %0d records in %0d random batches, %0d results checked",
                 records_sent, batches_run, results_seen);
        $display("quanta included zero, one and the 16-bit maximum; overfull tables included");
        if (errors == 0)
            $display("round_robin_process_scheduler_core verification clean");
        else
            $display("round_robin_process_scheduler_core verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("round_robin_process_scheduler_core verification failed");
        $finish;
    end

endmodule
